// ===== src/pdrs_pkg.sv =====
// Package for the priority disk request scheduler.
// Holds item and entry types, queue operation codes, status codes and fixed constants.
// No dependencies.
package pdrs_pkg;

  localparam int QUEUE_COUNT = 4;
  localparam int DISK_C      = 5;

  localparam logic [1:0] ST_ENQUEUED   = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  localparam logic CMD_ENQUEUE  = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [1:0] REG_PICK_POLICY = 2'd0;
  localparam logic [1:0] REG_RAID_MODE   = 2'd1;
  localparam logic [1:0] REG_MAP_BASE    = 2'd2;
  localparam logic [1:0] REG_REGION_SIZE = 2'd3;

  localparam logic [1:0] RAID_STRIPE   = 2'd0;
  localparam logic [1:0] RAID_MIRROR   = 2'd1;
  localparam logic [1:0] RAID_PARITY   = 2'd2;
  localparam logic [1:0] RAID_UNMAPPED = 2'd3;

  localparam logic [1:0] QOP_HOLD   = 2'd0;
  localparam logic [1:0] QOP_APPEND = 2'd1;
  localparam logic [1:0] QOP_ROTATE = 2'd2;
  localparam logic [1:0] QOP_REMOVE = 2'd3;

  typedef logic [1:0] qop_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  queue_sel;
    logic [31:0] block;
    logic [1:0]  prio;
    logic        is_wr;
    logic [15:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  served_queue;
    logic [15:0] out_tag;
    logic [31:0] out_block;
    logic        out_wr;
    logic [32:0] latency;
    logic [47:0] sector;
  } out_item_t;

  typedef struct packed {
    logic [31:0] block;
    logic [1:0]  prio;
    logic        wr;
    logic [15:0] tag;
  } entry_t;

endpackage

// ===== src/pdrs_cell.sv =====
// One request slot of a queue row.
// Loads a new request, its upper neighbor or the row's first slot; depends on pdrs_pkg.
module pdrs_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  pdrs_pkg::qop_t     op,
  input  logic [CNT_W-1:0]   fill,
  input  logic [IDX_W-1:0]   best,
  input  pdrs_pkg::entry_t   new_entry,
  input  pdrs_pkg::entry_t   next_entry,
  input  pdrs_pkg::entry_t   first_entry,
  output pdrs_pkg::entry_t   entry
);
  import pdrs_pkg::*;

  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

  always_ff @(posedge clk) begin
    case (op)
      QOP_APPEND: begin
        if (fill == IDX) entry <= new_entry;
      end
      QOP_ROTATE: begin
        // The used part of the row turns by one; slot 0 wraps to the last used slot.
        if (IDX1 < fill) entry <= next_entry;
        else if (IDX1 == fill) entry <= first_entry;
      end
      QOP_REMOVE: begin
        if (IDX >= CNT_W'(best) && IDX1 < fill) entry <= next_entry;
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== src/pdrs_queue.sv =====
// One disk queue: a row of request slots in arrival order plus its fill count.
// Uses pdrs_cell and pdrs_pkg.
module pdrs_queue #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  pdrs_pkg::qop_t     op,
  input  logic [IDX_W-1:0]   best,
  input  pdrs_pkg::entry_t   new_entry,
  output pdrs_pkg::entry_t   head_entry,
  output logic [CNT_W-1:0]   fill
);
  import pdrs_pkg::*;

  entry_t slots [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t upper;
      if (i == DEPTH - 1) begin : g_last
        assign upper = slots[i];
      end else begin : g_mid
        assign upper = slots[i+1];
      end
      pdrs_cell #(.INDEX(i), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_cell (
        .clk         (clk),
        .op          (op),
        .fill        (fill),
        .best        (best),
        .new_entry   (new_entry),
        .next_entry  (upper),
        .first_entry (slots[0]),
        .entry       (slots[i])
      );
    end
  endgenerate

  assign head_entry = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      case (op)
        QOP_APPEND: fill <= fill + CNT_W'(1);
        QOP_REMOVE: fill <= fill - CNT_W'(1);
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== src/priority_disk_request_scheduler.sv =====
// Top level of the priority disk request scheduler.
// Uses pdrs_queue (rows of pdrs_cell) and pdrs_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command per transfer:
//   enqueue a request into a disk queue, or dispatch the next request.
//   Output channel out_valid/out_stall/out_data returns exactly one result per
//   command. Configuration writes use cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high and writes belong in idle periods.
// Sequencing:
//   An enqueue passes from transfer through S_DECODE to S_DONE. In a dispatch
//   each stored request of the chosen queue is examined once as the queue row
//   turns past its first slot; the removal step S_REMOVE and the sector mapping
//   steps S_MAP1 to S_MAP4 follow. A dispatch that finds every queue empty
//   goes from S_DECODE to S_DONE. One command is in work at a time.
// Reset (rst, synchronous) empties all queues, zeroes the head positions and
// the round robin pointer, and loads the register defaults. While the receiver
// stalls, a finished result stays in the output register and one more command
// may be accepted and worked; its result then waits until the register frees.
module priority_disk_request_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BLOCK_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pdrs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pdrs_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import pdrs_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [47:0] SECTOR_MULT = 48'(BLOCK_BYTES / 512);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_REMOVE = 4'd3;
  localparam logic [3:0] S_MAP1   = 4'd4;
  localparam logic [3:0] S_MAP2   = 4'd5;
  localparam logic [3:0] S_MAP3   = 4'd6;
  localparam logic [3:0] S_MAP4   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;

  logic        pick_policy;
  logic [1:0]  raid_mode;
  logic [31:0] map_base;
  logic [31:0] disk_region_size;

  in_item_t  item;
  out_item_t res;

  logic [31:0] head_position [QUEUE_COUNT];
  logic [1:0]  last_served;
  logic [1:0]  cur_q;
  logic [CNT_W-1:0] scan_cnt;

  entry_t           best_entry;
  logic [31:0]      best_seek;
  logic [IDX_W-1:0] best_idx;

  logic             below;
  logic [31:0]      nval;
  logic [63:0]      quot_prod;
  logic [33:0]      rterm;
  logic [34:0]      phys;

  qop_t             cur_op;
  entry_t           new_entry;
  entry_t           heads [QUEUE_COUNT];
  logic [CNT_W-1:0] fills [QUEUE_COUNT];

  // A result that carries only a status; every other field is zero.
  function automatic out_item_t status_only(logic [1:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  assign new_entry = '{block: item.block, prio: item.prio, wr: item.is_wr, tag: item.tag};

  genvar g;
  generate
    for (g = 0; g < QUEUE_COUNT; g++) begin : g_queue
      qop_t q_op;
      assign q_op = (cur_q == 2'(g)) ? cur_op : QOP_HOLD;
      pdrs_queue #(.DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_queue (
        .clk        (clk),
        .rst        (rst),
        .op         (q_op),
        .best       (best_idx),
        .new_entry  (new_entry),
        .head_entry (heads[g]),
        .fill       (fills[g])
      );
    end
  endgenerate

  // Round robin choice of the first non-empty queue after the last one served.
  logic       rr_found;
  logic [1:0] rr_q;
  always_comb begin
    logic [1:0] cand;
    rr_found = 1'b0;
    rr_q     = '0;
    for (int k = 0; k < QUEUE_COUNT; k++) begin
      cand = last_served + 2'(k + 1);
      if (!rr_found && fills[cand] != '0) begin
        rr_found = 1'b1;
        rr_q     = cand;
      end
    end
  end

  // Comparison of the request now in the first slot of the scanned queue.
  entry_t      scan_e;
  logic [31:0] scan_head;
  logic [31:0] scan_dist;
  logic        scan_better;
  assign scan_e    = heads[cur_q];
  assign scan_head = head_position[cur_q];
  assign scan_dist = (scan_head >= scan_e.block) ? scan_head - scan_e.block
                                                 : scan_e.block - scan_head;
  assign scan_better = (scan_cnt == '0) || (scan_e.prio < best_entry.prio) ||
                       (pick_policy && scan_e.prio == best_entry.prio &&
                        scan_dist < best_seek);

  always_comb begin
    cur_op = QOP_HOLD;
    case (state)
      S_DECODE: begin
        if (item.cmd == CMD_ENQUEUE && fills[cur_q] != DEPTH_CNT) cur_op = QOP_APPEND;
      end
      S_SCAN:   cur_op = QOP_ROTATE;
      S_REMOVE: cur_op = QOP_REMOVE;
      default: begin
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_policy      <= 1'b0;
      raid_mode        <= RAID_PARITY;
      map_base         <= '0;
      disk_region_size <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PICK_POLICY: pick_policy      <= cfg_data[0];
        REG_RAID_MODE:   raid_mode        <= cfg_data[1:0];
        REG_MAP_BASE:    map_base         <= cfg_data;
        REG_REGION_SIZE: disk_region_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      last_served <= '0;
      cur_q       <= '0;
      for (int k = 0; k < QUEUE_COUNT; k++) head_position[k] <= '0;
    end else begin
      // In S_DONE the output register is reloaded whenever it frees.
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            cur_q <= in_data.queue_sel;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (item.cmd == CMD_ENQUEUE) begin
            res   <= status_only((fills[cur_q] == DEPTH_CNT) ? ST_FULL : ST_ENQUEUED);
            state <= S_DONE;
          end else if (!rr_found) begin
            res   <= status_only(ST_EMPTY);
            state <= S_DONE;
          end else begin
            cur_q    <= rr_q;
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_better) begin
            best_entry <= scan_e;
            best_seek  <= scan_dist;
            best_idx   <= scan_cnt[IDX_W-1:0];
          end
          scan_cnt <= scan_cnt + CNT_W'(1);
          if (scan_cnt + CNT_W'(1) == fills[cur_q]) state <= S_REMOVE;
        end
        S_REMOVE: begin
          head_position[cur_q] <= best_entry.block;
          last_served          <= cur_q;
          res.status           <= ST_DISPATCHED;
          res.served_queue     <= cur_q;
          res.out_tag          <= best_entry.tag;
          res.out_block        <= best_entry.block;
          res.out_wr           <= best_entry.wr;
          res.latency          <= {1'b0, best_seek} + 33'(DISK_C);
          state                <= S_MAP1;
        end
        S_MAP1: begin
          below <= best_entry.block < map_base;
          nval  <= best_entry.block - map_base;
          state <= S_MAP2;
        end
        S_MAP2: begin
          // n / 3 as a multiply by the reciprocal, exact for 32-bit n.
          quot_prod <= {32'd0, nval} * {32'd0, RECIP3};
          rterm     <= {2'b00, disk_region_size} *
                       34'((raid_mode == RAID_STRIPE) ? nval[1:0] : cur_q);
          state     <= S_MAP3;
        end
        S_MAP3: begin
          if (below) begin
            phys <= {3'b000, best_entry.block};
          end else begin
            case (raid_mode)
              RAID_STRIPE: phys <= {3'b000, map_base} + {1'b0, rterm} +
                                   {5'd0, nval[31:2]};
              RAID_MIRROR: phys <= {3'b000, map_base} + {1'b0, rterm} +
                                   {3'b000, nval};
              RAID_PARITY: phys <= {3'b000, map_base} + {1'b0, rterm} +
                                   {4'd0, quot_prod[63:33]};
              default:     phys <= '0;
            endcase
          end
          state <= S_MAP4;
        end
        S_MAP4: begin
          res.sector <= 48'({13'd0, phys} * SECTOR_MULT);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
